>>> hdl/mqtt_connect_parser_responder_macros.svh
// ----------------------------------------------------------------------------
// mqtt_connect_parser_responder_macros
// Assertion helpers shared by the parser/responder RTL.
// ----------------------------------------------------------------------------
`ifndef MQTT_CONNECT_PARSER_RESPONDER_MACROS_SVH
`define MQTT_CONNECT_PARSER_RESPONDER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MCPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled while in reset
`define MCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> hdl/mcpr_pkg.sv
// ----------------------------------------------------------------------------
// mcpr_pkg
// Types, constants and helpers of the MQTT CONNECT parser/responder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcpr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 8;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_REMLEN  = 4'd1,
    PH_NLEN_H  = 4'd2,
    PH_NLEN_L  = 4'd3,
    PH_NAME    = 4'd4,
    PH_VERSION = 4'd5,
    PH_FLAGS   = 4'd6,
    PH_KA_H    = 4'd7,
    PH_KA_L    = 4'd8,
    PH_SLEN_H  = 4'd9,
    PH_SLEN_L  = 4'd10,
    PH_SDATA   = 4'd11,
    PH_DONE    = 4'd12,
    PH_PING    = 4'd13
  } mcpr_phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_RESPONSE = 2'd1,
    KIND_ERROR    = 2'd2
  } mcpr_kind_e;

  typedef enum logic [2:0] {
    ERR_BAD_HEADER   = 3'd0,
    ERR_NAME_LEN     = 3'd1,
    ERR_NAME         = 3'd2,
    ERR_VERSION      = 3'd3,
    ERR_CONNECTED    = 3'd4,
    ERR_TRUNCATED    = 3'd5,
    ERR_UNKNOWN_TYPE = 3'd6
  } mcpr_err_e;

  typedef enum logic [2:0] {
    TAG_IDENT      = 3'd0,
    TAG_WILL_TOPIC = 3'd1,
    TAG_WILL_MSG   = 3'd2,
    TAG_USERNAME   = 3'd3,
    TAG_PASSWORD   = 3'd4,
    TAG_NONE       = 3'd7
  } mcpr_tag_e;

  typedef enum logic [1:0] {
    RESP_NONE     = 2'd0,
    RESP_PINGRESP = 2'd1,
    RESP_CONNACK  = 2'd2
  } mcpr_resp_e;

  // configuration register indexes
  localparam logic CFG_PROTO_VERSION = 1'b0;
  localparam logic CFG_CONNACK_RC    = 1'b1;

  localparam logic [3:0]  PKT_CONNECT    = 4'd1;
  localparam logic [3:0]  PKT_PINGREQ    = 4'd12;
  localparam logic [15:0] NAME_LEN       = 16'd6;
  localparam logic [7:0]  FLAG_USER      = 8'h80;
  localparam logic [7:0]  FLAG_PASS      = 8'h40;
  localparam logic [7:0]  FLAG_WILL      = 8'h04;
  localparam logic [7:0]  PINGRESP_HDR   = 8'hD0;
  localparam logic [7:0]  CONNACK_HDR    = 8'h20;
  localparam logic [7:0]  CONNACK_REMLEN = 8'h02;
  localparam logic [7:0]  ZERO_BYTE      = 8'h00;
  localparam logic [7:0]  PROTO_VER_RST  = 8'd3;

  // one queued item: everything the back end needs to produce its results
  typedef struct packed {
    logic          has_pay;
    mcpr_tag_e     pay_tag;
    logic [7:0]    pay_byte;
    logic          has_err;
    mcpr_err_e     err;
    mcpr_resp_e    resp;
    logic [7:0]    rc;
    logic [15:0]   ka;
    logic [7:0]    flags;
    logic          conn;
  } mcpr_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mcpr_qstat_t;

  function automatic logic [7:0] proto_name_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h4D;  // M
      3'd1:    r = 8'h51;  // Q
      3'd2:    r = 8'h49;  // I
      3'd3:    r = 8'h73;  // s
      3'd4:    r = 8'h64;  // d
      3'd5:    r = 8'h70;  // p
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // next optional payload string after the given one, from the connect flags
  function automatic mcpr_tag_e next_tag(input mcpr_tag_e after, input logic [7:0] flags);
    logic      will;
    logic [2:0] a;
    mcpr_tag_e r;
    will = |(flags & FLAG_WILL);
    a    = after;
    if (a < 3'd1 && will) begin
      r = TAG_WILL_TOPIC;
    end else if (a < 3'd2 && will) begin
      r = TAG_WILL_MSG;
    end else if (a < 3'd3 && |(flags & FLAG_USER)) begin
      r = TAG_USERNAME;
    end else if (a < 3'd4 && |(flags & FLAG_PASS)) begin
      r = TAG_PASSWORD;
    end else begin
      r = TAG_NONE;
    end
    return r;
  endfunction

endpackage

>>> hdl/mcpr_front.sv
// ----------------------------------------------------------------------------
// mcpr_front
// Byte parser: walks the packet one byte per cycle while the queue has room,
// keeps the session state and pushes one descriptor per byte that causes any result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcpr_front import mcpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_eop_i,
  input  mcpr_qstat_t qstat_i,
  output logic        push_o,
  output mcpr_desc_t  desc_o,
  output logic        conn_o
);

  mcpr_phase_e phase_q, phase_d, step_phase;
  mcpr_tag_e   tag_q, tag_d, tag_step;
  logic [3:0]  ptype_q, ptype_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  lhigh_q, lhigh_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] ka_q, ka_d;
  logic        err_seen_q, err_seen_d;
  logic        conn_q, conn_d;
  logic [7:0]  ver_q, rc_q;

  logic        accept;
  logic        step_fail, step_pay, eop_fail;
  mcpr_err_e   step_err;
  mcpr_resp_e  eop_resp;
  mcpr_tag_e   nt;
  logic [15:0] len_word, count_inc;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign len_word   = {lhigh_q, in_byte_i};
  assign count_inc  = count_q + 16'd1;
  assign nt         = next_tag(tag_q, flags_q);

  // per-phase handling of the byte
  always_comb begin
    step_phase = phase_q;
    tag_step   = tag_q;
    ptype_d    = ptype_q;
    count_d    = count_q;
    lhigh_d    = lhigh_q;
    flags_d    = flags_q;
    ka_d       = ka_q;
    step_fail  = 1'b0;
    step_err   = ERR_BAD_HEADER;
    step_pay   = 1'b0;
    if (!err_seen_q) begin
      case (phase_q)
        PH_HEADER: begin
          ptype_d = in_byte_i[7:4];
          if (in_byte_i[7:4] == PKT_PINGREQ) begin
            step_phase = PH_REMLEN;
          end else if (in_byte_i[7:4] == PKT_CONNECT) begin
            if (conn_q) begin
              step_fail = 1'b1;
              step_err  = ERR_CONNECTED;
            end else if (in_byte_i[3:0] != 4'd0) begin
              step_fail = 1'b1;
              step_err  = ERR_BAD_HEADER;
            end else begin
              step_phase = PH_REMLEN;
            end
          end else begin
            step_fail = 1'b1;
            step_err  = ERR_UNKNOWN_TYPE;
          end
        end
        PH_REMLEN: begin
          // continuation bit clear ends the remaining length
          if (!in_byte_i[7]) begin
            step_phase = (ptype_q == PKT_PINGREQ) ? PH_PING : PH_NLEN_H;
          end
        end
        PH_NLEN_H: begin
          lhigh_d    = in_byte_i;
          step_phase = PH_NLEN_L;
        end
        PH_NLEN_L: begin
          if (len_word != NAME_LEN) begin
            step_fail = 1'b1;
            step_err  = ERR_NAME_LEN;
          end else begin
            count_d    = 16'd0;
            step_phase = PH_NAME;
          end
        end
        PH_NAME: begin
          if (in_byte_i != proto_name_byte(count_q[2:0])) begin
            step_fail = 1'b1;
            step_err  = ERR_NAME;
          end else begin
            count_d = count_inc;
            if (count_inc >= NAME_LEN) begin
              step_phase = PH_VERSION;
            end
          end
        end
        PH_VERSION: begin
          if (in_byte_i != ver_q) begin
            step_fail = 1'b1;
            step_err  = ERR_VERSION;
          end else begin
            step_phase = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          flags_d    = in_byte_i;
          step_phase = PH_KA_H;
        end
        PH_KA_H: begin
          lhigh_d    = in_byte_i;
          step_phase = PH_KA_L;
        end
        PH_KA_L: begin
          ka_d       = len_word;
          tag_step   = TAG_IDENT;
          step_phase = PH_SLEN_H;
        end
        PH_SLEN_H: begin
          lhigh_d    = in_byte_i;
          step_phase = PH_SLEN_L;
        end
        PH_SLEN_L: begin
          count_d = len_word;
          if (len_word == 16'd0) begin
            if (nt == TAG_NONE) begin
              step_phase = PH_DONE;
            end else begin
              tag_step   = nt;
              step_phase = PH_SLEN_H;
            end
          end else begin
            step_phase = PH_SDATA;
          end
        end
        PH_SDATA: begin
          step_pay = 1'b1;
          count_d  = count_q - 16'd1;
          if (count_q == 16'd1) begin
            if (nt == TAG_NONE) begin
              step_phase = PH_DONE;
            end else begin
              tag_step   = nt;
              step_phase = PH_SLEN_H;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // next state, including the end-of-packet decision
  always_comb begin
    phase_d    = step_phase;
    tag_d      = tag_step;
    err_seen_d = err_seen_q | step_fail;
    conn_d     = conn_q;
    eop_resp   = RESP_NONE;
    eop_fail   = 1'b0;
    if (in_eop_i) begin
      if (!err_seen_d) begin
        if (ptype_d == PKT_PINGREQ) begin
          eop_resp = RESP_PINGRESP;
        end else if (step_phase == PH_DONE ||
                     (step_phase inside {PH_SLEN_H, PH_SLEN_L} &&
                      tag_step inside {TAG_USERNAME, TAG_PASSWORD})) begin
          // a missing username/password at packet end counts as absent
          eop_resp = RESP_CONNACK;
          conn_d   = 1'b1;
        end else begin
          eop_fail = 1'b1;
        end
      end
      phase_d    = PH_HEADER;
      err_seen_d = 1'b0;
    end
  end

  // descriptor for the queue
  always_comb begin
    desc_o.has_pay  = step_pay;
    desc_o.pay_tag  = tag_q;
    desc_o.pay_byte = in_byte_i;
    desc_o.has_err  = step_fail | eop_fail;
    desc_o.err      = step_fail ? step_err : ERR_TRUNCATED;
    desc_o.resp     = eop_resp;
    desc_o.rc       = rc_q;
    desc_o.ka       = ka_d;
    desc_o.flags    = flags_d;
    desc_o.conn     = conn_d;
    push_o = accept && (step_pay || step_fail || eop_fail || eop_resp != RESP_NONE);
  end

  assign conn_o = conn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      tag_q      <= TAG_IDENT;
      ptype_q    <= 4'd0;
      count_q    <= 16'd0;
      lhigh_q    <= 8'd0;
      flags_q    <= 8'd0;
      ka_q       <= 16'd0;
      err_seen_q <= 1'b0;
      conn_q     <= 1'b0;
    end else if (accept) begin
      phase_q    <= phase_d;
      tag_q      <= tag_d;
      ptype_q    <= ptype_d;
      count_q    <= count_d;
      lhigh_q    <= lhigh_d;
      flags_q    <= flags_d;
      ka_q       <= ka_d;
      err_seen_q <= err_seen_d;
      conn_q     <= conn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q <= PROTO_VER_RST;
      rc_q  <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PROTO_VERSION: ver_q <= cfg_wdata_i;
        CFG_CONNACK_RC:    rc_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/mcpr_queue.sv
// ----------------------------------------------------------------------------
// mcpr_queue
// Small descriptor FIFO between the parser and the result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcpr_queue import mcpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  mcpr_desc_t  desc_i,
  input  logic        pop_i,
  output mcpr_desc_t  desc_o,
  output mcpr_qstat_t qstat_o
);

  mcpr_desc_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCntW'(1);
      2'b01:   cnt_d = cnt_q - QCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= desc_i;
  end

  assign desc_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == QCntW'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);

endmodule

>>> hdl/mcpr_back.sv
// ----------------------------------------------------------------------------
// mcpr_back
// Result sequencer: expands the head descriptor into its result items, one
// per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcpr_back import mcpr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcpr_desc_t          desc_i,
  input  mcpr_qstat_t         qstat_i,
  output logic                pop_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,
  output logic [OutUserW-1:0] m_tuser_o,
  output logic                m_tlast_o
);

  logic [2:0]  idx_q, idx_d, res_cnt, resp_len, rq;
  logic        out_valid_q, out_valid_d;
  logic [OutDataW-1:0] data_q;
  logic [OutUserW-1:0] user_q;
  logic        last_q;

  logic        load, is_last;
  mcpr_kind_e  kind;
  mcpr_tag_e   tag;
  mcpr_err_e   err;
  logic [7:0]  obyte;

  always_comb begin
    case (desc_i.resp)
      RESP_PINGRESP: resp_len = 3'd2;
      RESP_CONNACK:  resp_len = 3'd4;
      default:       resp_len = 3'd0;
    endcase
    res_cnt = {2'b00, desc_i.has_pay} + {2'b00, desc_i.has_err} + resp_len;
    is_last = (idx_q == res_cnt - 3'd1);
    rq      = idx_q - {2'b00, desc_i.has_pay};
  end

  // result at position idx_q: payload byte, then error or response bytes
  always_comb begin
    kind  = KIND_RESPONSE;
    tag   = TAG_IDENT;
    err   = ERR_BAD_HEADER;
    obyte = ZERO_BYTE;
    if (desc_i.has_pay && idx_q == 3'd0) begin
      kind  = KIND_PAYLOAD;
      tag   = desc_i.pay_tag;
      obyte = desc_i.pay_byte;
    end else if (desc_i.has_err) begin
      kind = KIND_ERROR;
      err  = desc_i.err;
    end else if (desc_i.resp == RESP_PINGRESP) begin
      obyte = (rq == 3'd0) ? PINGRESP_HDR : ZERO_BYTE;
    end else begin
      case (rq)
        3'd0:    obyte = CONNACK_HDR;
        3'd1:    obyte = CONNACK_REMLEN;
        3'd2:    obyte = ZERO_BYTE;
        default: obyte = desc_i.rc;
      endcase
    end
  end

  assign load  = !qstat_i.empty && (!out_valid_q || m_tready_i);
  assign pop_o = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = is_last ? 3'd0 : idx_q + 3'd1;
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= {4'b0000, desc_i.conn, desc_i.flags, desc_i.ka, err, obyte};
      user_q <= {3'b000, tag, kind};
      last_q <= is_last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = user_q;
  assign m_tlast_o  = last_q;

endmodule

>>> hdl/mqtt_connect_parser_responder.sv
// ----------------------------------------------------------------------------
// mqtt_connect_parser_responder
// MQTT 3.1 CONNECT / PINGREQ parser with CONNACK / PINGRESP responder.
// ----------------------------------------------------------------------------
// The input stream takes one packet byte per cycle at all times while the
// descriptor queue (4 entries) has room. Each byte that causes results turns
// into one queued descriptor; the back end drains it one result per cycle,
// when the output is not stalled, so a byte with k results (1 to 5: a payload
// byte, an error report, the 2-byte PINGRESP or the 4-byte CONNACK) gives k
// output transfers. Sustained rate is one byte per cycle for payload traffic
// without output stalls and is set by the result sequencer for packet-end
// bytes. A byte's first result is registered in the queue, then in the output
// register. tlast marks the last result of one input byte.
`timescale 1ns / 1ps
`include "mqtt_connect_parser_responder_macros.svh"

module mqtt_connect_parser_responder import mcpr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] in_byte
  input  logic [7:0]          s_axis_tdata,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] out_byte, [10:8] error_code, [26:11] keepalive_seconds,
  // [34:27] connect_flags, [35] connected, [39:36] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [1:0] out_kind, [4:2] field_tag, [7:5] zero
  output logic [OutUserW-1:0] m_axis_tuser,
  output logic                m_axis_tlast
);

  logic        push, pop, conn;
  mcpr_desc_t  desc_in, desc_head;
  mcpr_qstat_t qstat;

  mcpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eop_i    (s_axis_tlast),
    .qstat_i     (qstat),
    .push_o      (push),
    .desc_o      (desc_in),
    .conn_o      (conn)
  );

  mcpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .pop_i   (pop),
    .desc_o  (desc_head),
    .qstat_o (qstat)
  );

  mcpr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .desc_i     (desc_head),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  `MCPR_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push, !qstat.full)
  `MCPR_ASSERT_NEXT(a_conn_sticky, clk_i, rst_ni, conn, conn)
  `MCPR_ASSERT_IMPL(a_rest_queued, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !qstat.empty)
  `MCPR_ASSERT_NEXT(a_pop_at_last, clk_i, rst_ni, pop, m_axis_tvalid && m_axis_tlast)

endmodule

>>> tb/sv/tb_mqtt_connect_parser_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mqtt_connect_parser_responder
// Stream testbench for the MQTT 3.1 CONNECT / PINGREQ parser and responder.
// A cycle-free predictor tracks the parse state for every accepted packet
// byte and queues the payload, response and error transactions that byte
// must produce. The checker compares every output transaction field by field
// with the oldest queued entry. Header and protocol error cases are driven
// first. Then come mostly well-formed CONNECTs with random content that are
// cut short, plus broken CONNECTs, PINGREQs and noise. One CONNECT is then
// accepted, and traffic continues in the connected state.
// ----------------------------------------------------------------------------

module tb_mqtt_connect_parser_responder;
  import mcpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned RAND_ITEMS   = 270;
  localparam int unsigned MAX_PER_BYTE = 5;
  localparam logic [47:0] PROTO_NAME   = 48'h4D5149736470;  // "MQIsdp"

  typedef struct {
    mcpr_kind_e  kind;
    mcpr_tag_e   tag;
    logic [7:0]  data;
    logic        last;
    mcpr_err_e   err;
    logic [15:0] keepalive;
    logic [7:0]  flags;
    logic        conn;
  } result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_addr_i;
  logic [7:0]          cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                m_axis_tlast;

  // predictor state
  logic        conn_q;
  mcpr_phase_e phase_q;
  logic [3:0]  ptype_q;
  logic [15:0] cnt_q;
  logic [7:0]  hi_q;
  logic [7:0]  flags_q;
  logic [15:0] ka_q;
  logic        err_q;
  mcpr_tag_e   tag_q;
  logic [7:0]  version_cfg;
  logic [7:0]  rc_cfg;

  result_t     pending_results[$];
  result_t     step_results[$];
  logic [7:0]  pkt_bytes[$];
  int unsigned body_pos;   // index of the protocol name length
  int unsigned user_pos;   // index of the username length
  int unsigned pass_pos;   // index of the password length

  bit          quiet_link;
  int unsigned fail_cnt;
  int unsigned sent_total;
  int unsigned n_payload, n_resp, n_err;
  int unsigned cycle_cnt;

  mqtt_connect_parser_responder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] name_char(input logic [15:0] idx);
    if (idx < NAME_LEN) begin
      return PROTO_NAME[8*(5-idx) +: 8];
    end
    return ZERO_BYTE;
  endfunction

  function automatic void add_result(input mcpr_kind_e kind, input mcpr_tag_e tag,
                                     input logic [7:0] data, input mcpr_err_e err);
    result_t r;
    if (step_results.size() < MAX_PER_BYTE) begin
      r.kind = kind;
      r.tag  = tag;
      r.data = data;
      r.err  = err;
      r.last = 1'b0;
      step_results.push_back(r);
    end
  endfunction

  function automatic void raise_error(input mcpr_err_e code);
    add_result(KIND_ERROR, TAG_IDENT, ZERO_BYTE, code);
    err_q = 1'b1;
  endfunction

  // pick the next optional string from the stored connect flags
  function automatic void advance_field();
    logic will;
    will = |(flags_q & FLAG_WILL);
    if (tag_q < TAG_WILL_TOPIC && will) begin
      tag_q = TAG_WILL_TOPIC;
    end else if (tag_q < TAG_WILL_MSG && will) begin
      tag_q = TAG_WILL_MSG;
    end else if (tag_q < TAG_USERNAME && |(flags_q & FLAG_USER)) begin
      tag_q = TAG_USERNAME;
    end else if (tag_q < TAG_PASSWORD && |(flags_q & FLAG_PASS)) begin
      tag_q = TAG_PASSWORD;
    end else begin
      phase_q = PH_DONE;
      return;
    end
    phase_q = PH_SLEN_H;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic eop);
    logic [15:0] word;
    word = {hi_q, b};
    step_results.delete();
    if (!err_q) begin
      case (phase_q)
        PH_HEADER: begin
          ptype_q = b[7:4];
          if (ptype_q == PKT_PINGREQ) begin
            phase_q = PH_REMLEN;
          end else if (ptype_q == PKT_CONNECT) begin
            // connected state wins over the low nibble check
            if (conn_q) raise_error(ERR_CONNECTED);
            else if (b[3:0] != 4'd0) raise_error(ERR_BAD_HEADER);
            else phase_q = PH_REMLEN;
          end else begin
            raise_error(ERR_UNKNOWN_TYPE);
          end
        end
        PH_REMLEN: begin
          if (!b[7]) phase_q = (ptype_q == PKT_PINGREQ) ? PH_PING : PH_NLEN_H;
        end
        PH_NLEN_H: begin
          hi_q    = b;
          phase_q = PH_NLEN_L;
        end
        PH_NLEN_L: begin
          if (word != NAME_LEN) begin
            raise_error(ERR_NAME_LEN);
          end else begin
            cnt_q   = '0;
            phase_q = PH_NAME;
          end
        end
        PH_NAME: begin
          if (b != name_char(cnt_q)) begin
            raise_error(ERR_NAME);
          end else begin
            cnt_q++;
            if (cnt_q >= NAME_LEN) phase_q = PH_VERSION;
          end
        end
        PH_VERSION: begin
          if (b != version_cfg) raise_error(ERR_VERSION);
          else phase_q = PH_FLAGS;
        end
        PH_FLAGS: begin
          flags_q = b;
          phase_q = PH_KA_H;
        end
        PH_KA_H: begin
          hi_q    = b;
          phase_q = PH_KA_L;
        end
        PH_KA_L: begin
          ka_q    = word;
          tag_q   = TAG_IDENT;
          phase_q = PH_SLEN_H;
        end
        PH_SLEN_H: begin
          hi_q    = b;
          phase_q = PH_SLEN_L;
        end
        PH_SLEN_L: begin
          cnt_q = word;
          if (word == 16'd0) advance_field();
          else phase_q = PH_SDATA;
        end
        PH_SDATA: begin
          add_result(KIND_PAYLOAD, tag_q, b, ERR_BAD_HEADER);
          cnt_q--;
          if (cnt_q == 16'd0) advance_field();
        end
        default: begin
        end
      endcase
    end

    if (eop) begin
      if (!err_q) begin
        if (ptype_q == PKT_PINGREQ) begin
          add_result(KIND_RESPONSE, TAG_IDENT, PINGRESP_HDR, ERR_BAD_HEADER);
          add_result(KIND_RESPONSE, TAG_IDENT, ZERO_BYTE, ERR_BAD_HEADER);
        end else if (phase_q == PH_DONE ||
                     ((phase_q == PH_SLEN_H || phase_q == PH_SLEN_L) &&
                      tag_q >= TAG_USERNAME)) begin
          // username / password missing at packet end counts as absent
          add_result(KIND_RESPONSE, TAG_IDENT, CONNACK_HDR, ERR_BAD_HEADER);
          add_result(KIND_RESPONSE, TAG_IDENT, CONNACK_REMLEN, ERR_BAD_HEADER);
          add_result(KIND_RESPONSE, TAG_IDENT, ZERO_BYTE, ERR_BAD_HEADER);
          add_result(KIND_RESPONSE, TAG_IDENT, rc_cfg, ERR_BAD_HEADER);
          conn_q = 1'b1;
        end else begin
          raise_error(ERR_TRUNCATED);
        end
      end
      phase_q = PH_HEADER;
      err_q   = 1'b0;
    end

    foreach (step_results[i]) begin
      step_results[i].last      = (i == step_results.size() - 1);
      step_results[i].keepalive = ka_q;
      step_results[i].flags     = flags_q;
      step_results[i].conn      = conn_q;
      pending_results.push_back(step_results[i]);
    end
  endfunction

  // ------------------------------------------------------------------ checker

  function automatic void compare_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  function automatic void check_result();
    result_t r;
    if (pending_results.size() == 0) begin
      fail_cnt++;
      $display("%0t: unexpected transaction: expected none, actual tdata=%h tuser=%h",
               $time, m_axis_tdata, m_axis_tuser);
      return;
    end
    r = pending_results.pop_front();
    compare_field("out_kind", 16'(r.kind), 16'(m_axis_tuser[1:0]));
    compare_field("field_tag", 16'(r.tag), 16'(m_axis_tuser[4:2]));
    compare_field("out_byte", 16'(r.data), 16'(m_axis_tdata[7:0]));
    compare_field("last_of_run", 16'(r.last), 16'(m_axis_tlast));
    compare_field("error_code", 16'(r.err), 16'(m_axis_tdata[10:8]));
    compare_field("keepalive_seconds", r.keepalive, m_axis_tdata[26:11]);
    compare_field("connect_flags", 16'(r.flags), 16'(m_axis_tdata[34:27]));
    compare_field("connected", 16'(r.conn), 16'(m_axis_tdata[35]));
    case (r.kind)
      KIND_PAYLOAD:  n_payload++;
      KIND_RESPONSE: n_resp++;
      default:       n_err++;
    endcase
  endfunction

  // outputs are checked before the input of the same edge is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= quiet_link ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transactions outstanding", $time,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic send_item(input logic [7:0] b, input logic eop);
    if (!quiet_link) begin
      while ($urandom_range(0, 99) < 14) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eop;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_total++;
  endtask

  task automatic send_packet(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(pkt_bytes[i], i == len - 1);
    end
    pkt_bytes.delete();
  endtask

  // stop sending, wait for every transaction plus the pipeline latency
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PROTO_VERSION) version_cfg = value;
    else rc_cfg = value;
    @(posedge clk_i);
  endtask

  function automatic void push_remlen();
    int unsigned n;
    n = $urandom_range(1, 3);
    for (int unsigned i = 1; i < n; i++) pkt_bytes.push_back(8'h80 | 8'($urandom));
    pkt_bytes.push_back(8'($urandom) & 8'h7F);
  endfunction

  function automatic void push_string(input int unsigned max_len);
    logic [15:0] len;
    len = 16'($urandom_range(0, max_len));
    pkt_bytes.push_back(len[15:8]);
    pkt_bytes.push_back(len[7:0]);
    for (int unsigned i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom));
  endfunction

  // full CONNECT; returns the length up to the end of the mandatory strings
  task automatic build_connect(input logic [7:0] flags, input logic [15:0] ka,
                               input int unsigned max_len, output int unsigned req_len);
    pkt_bytes.delete();
    pkt_bytes.push_back({PKT_CONNECT, 4'h0});
    push_remlen();
    body_pos = pkt_bytes.size();
    pkt_bytes.push_back(NAME_LEN[15:8]);
    pkt_bytes.push_back(NAME_LEN[7:0]);
    for (int unsigned i = 0; i < NAME_LEN; i++) pkt_bytes.push_back(name_char(16'(i)));
    pkt_bytes.push_back(version_cfg);
    pkt_bytes.push_back(flags);
    pkt_bytes.push_back(ka[15:8]);
    pkt_bytes.push_back(ka[7:0]);
    push_string(max_len);
    if (|(flags & FLAG_WILL)) begin
      push_string(max_len);
      push_string(max_len);
    end
    req_len  = pkt_bytes.size();
    user_pos = pkt_bytes.size();
    if (|(flags & FLAG_USER)) push_string(max_len);
    pass_pos = pkt_bytes.size();
    if (|(flags & FLAG_PASS)) push_string(max_len);
  endtask

  // well-formed CONNECT cut before its mandatory part is complete
  task automatic send_cut_connect();
    int unsigned req_len;
    int unsigned deep_lo;
    int unsigned cut;
    build_connect(8'($urandom), 16'($urandom), 6, req_len);
    deep_lo = body_pos + 9;
    if ($urandom_range(0, 3) != 0) cut = $urandom_range(deep_lo, req_len - 1);
    else cut = $urandom_range(1, req_len - 1);
    send_packet(cut);
  endtask

  // CONNECT with one broken byte in the fixed or variable header
  task automatic send_broken_connect();
    int unsigned req_len;
    int unsigned pos;
    build_connect(8'($urandom), 16'($urandom), 4, req_len);
    pos = $urandom_range(0, 9);
    if (pos == 0) begin
      pkt_bytes[0] = pkt_bytes[0] ^ 8'($urandom_range(1, 15));
    end else begin
      pos = body_pos + pos - 1;
      pkt_bytes[pos] = pkt_bytes[pos] ^ 8'($urandom_range(1, 255));
    end
    send_packet($urandom_range(pos + 1, pkt_bytes.size()));
  endtask

  task automatic send_pingreq();
    pkt_bytes.push_back({PKT_PINGREQ, 4'($urandom)});
    if ($urandom_range(0, 4) != 0) push_remlen();
    repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
    send_packet(pkt_bytes.size());
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 5)) pkt_bytes.push_back(8'($urandom));
    send_packet(pkt_bytes.size());
  endtask

  // ----------------------------------------------------------------- tests

  task automatic test_header_cases();
    pkt_bytes = '{8'hC0, 8'h00};                      // plain PINGREQ
    send_packet(2);
    pkt_bytes = '{8'hCF};                             // low nibble ignored, no remlen
    send_packet(1);
    pkt_bytes = '{8'hC3, 8'h81, 8'h00, 8'hFF};        // multi-byte remlen, trailing
    send_packet(4);
    pkt_bytes = '{8'h00, 8'hFF, 8'h00};               // unknown type, rest ignored
    send_packet(3);
    pkt_bytes = '{8'hF0};
    send_packet(1);
    pkt_bytes = '{8'h1F, 8'h00};                      // CONNECT with bad low nibble
    send_packet(2);
    pkt_bytes = '{8'h10};                             // CONNECT ending in header
    send_packet(1);
    pkt_bytes = '{8'h10, 8'hFF, 8'h80, 8'h01, 8'h00, 8'h05};  // name length
    send_packet(6);
    pkt_bytes = '{8'h10, 8'h0C, 8'h00, 8'h06, 8'h4D, 8'h52};  // name mismatch
    send_packet(6);
    settle();
  endtask

  task automatic test_version_checks();
    logic [7:0] versions [3];
    int unsigned req_len;
    versions = '{8'h00, 8'hFF, PROTO_VER_RST};
    foreach (versions[i]) begin
      write_reg(CFG_PROTO_VERSION, versions[i]);
      write_reg(CFG_CONNACK_RC, 8'($urandom));
      build_connect(FLAG_WILL | FLAG_USER | FLAG_PASS, 16'($urandom), 3, req_len);
      send_packet(req_len - 1);
      build_connect(8'($urandom), 16'($urandom), 3, req_len);
      pkt_bytes[body_pos + 8] = ~version_cfg;
      send_packet(body_pos + 9 + $urandom_range(0, 2));
      settle();
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned start_cnt;
    int unsigned done_cnt;
    int unsigned next_cfg;
    int unsigned pick;
    start_cnt = sent_total;
    next_cfg  = 120;
    done_cnt  = 0;
    while (done_cnt < n_items) begin
      quiet_link = (done_cnt >= n_items / 3) && (done_cnt < n_items / 2);
      if (done_cnt >= next_cfg) begin
        settle();
        write_reg(CFG_PROTO_VERSION, ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'hFF);
        write_reg(CFG_CONNACK_RC, 8'($urandom));
        next_cfg += 120;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) send_cut_connect();
      else if (pick < 77) send_broken_connect();
      else if (pick < 88) send_pingreq();
      else send_noise();
      done_cnt = sent_total - start_cnt;
    end
    quiet_link = 1'b0;
    settle();
  endtask

  task automatic test_connect_accept();
    int unsigned req_len;
    int unsigned pick;
    write_reg(CFG_PROTO_VERSION, PROTO_VER_RST);
    write_reg(CFG_CONNACK_RC, ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom));
    build_connect(FLAG_WILL | FLAG_USER | FLAG_PASS | (8'($urandom) & 8'h3B),
                  ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom), 5, req_len);
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      send_packet(user_pos + $urandom_range(0, 1));   // username length cut off
    end else if (pick == 1) begin
      send_packet(pass_pos + $urandom_range(0, 1));   // password length cut off
    end else begin
      repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
      send_packet(pkt_bytes.size());
    end
    settle();
  endtask

  task automatic test_connected_traffic();
    int unsigned start_cnt;
    int unsigned req_len;
    int unsigned pick;
    start_cnt = sent_total;
    while (sent_total - start_cnt < 60) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        build_connect(8'($urandom), 16'($urandom), 3, req_len);
        pkt_bytes[0] = {PKT_CONNECT, 4'($urandom)};
        send_packet($urandom_range(1, pkt_bytes.size()));
      end else if (pick == 1) begin
        send_pingreq();
      end else begin
        send_noise();
      end
    end
    settle();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CFG_PROTO_VERSION;
    cfg_wdata_i   <= 8'h00;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    quiet_link  = 1'b0;
    fail_cnt    = 0;
    sent_total  = 0;
    n_payload   = 0;
    n_resp      = 0;
    n_err       = 0;
    cycle_cnt   = 0;
    conn_q      = 1'b0;
    phase_q     = PH_HEADER;
    ptype_q     = 4'd0;
    cnt_q       = '0;
    hi_q        = '0;
    flags_q     = '0;
    ka_q        = '0;
    err_q       = 1'b0;
    tag_q       = TAG_IDENT;
    version_cfg = PROTO_VER_RST;
    rc_cfg      = ZERO_BYTE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    test_header_cases();
    test_version_checks();
    test_random_traffic(RAND_ITEMS);
    test_connect_accept();
    test_connected_traffic();

    $display("Sent %0d packet bytes; checked %0d payload, %0d response, %0d error results",
             sent_total, n_payload, n_resp, n_err);
    $display("Connected state at end: %0d, protocol version setting %0h", conn_q, version_cfg);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
